// File: design/ir_pulse_distance_frame_decoder_defines.svh
// Assertion macros used by the IR frame state machine (ird_frame)
`ifndef IR_PULSE_DISTANCE_FRAME_DECODER_DEFINES_SVH
`define IR_PULSE_DISTANCE_FRAME_DECODER_DEFINES_SVH

// Checked on every rising clock edge outside reset
`define IRD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included
`define IRD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// File: design/ird_pkg.sv
// Types and constants of the IR pulse distance frame decoder
package ird_pkg;

    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned FRAME_BYTES  = 4;
    localparam int unsigned CNT_W        = 6;
    localparam int unsigned STATUS_W     = 2;
    localparam int unsigned CFG_IDX_W    = 2;
    localparam int unsigned FRAME_BITS_D = 32;
    localparam int unsigned IN_TDATA_W   = 8;
    localparam int unsigned OUT_TDATA_W  = 40;

    localparam logic [BYTE_W-1:0] LEADER_MIN_RST    = 8'd13;
    localparam logic [BYTE_W-1:0] BIT_THRESHOLD_RST = 8'd6;
    localparam logic [BYTE_W-1:0] GAP_MAX_RST       = 8'd20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEADER_MIN    = 2'd0,
        CFG_BIT_THRESHOLD = 2'd1,
        CFG_GAP_MAX       = 2'd2
    } t_cfg_idx;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_CHECK_FAIL = 2'd1,
        ST_ABORT      = 2'd2
    } t_status;

    typedef struct packed {
        logic [BYTE_W-1:0] leader_min;
        logic [BYTE_W-1:0] bit_threshold;
        logic [BYTE_W-1:0] gap_max;
    } t_cfg;

    typedef struct packed {
        logic                              valid;
        t_status                           status;
        logic [FRAME_BYTES-1:0][BYTE_W-1:0] bytes;
    } t_result;

endpackage

// File: design/ird_cfg_regs.sv
// Configuration registers of the IR frame decoder
module ird_cfg_regs
    import ird_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_we,
    input  logic [CFG_IDX_W-1:0]  i_idx,
    input  logic [BYTE_W-1:0]     i_wdata,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.leader_min    <= LEADER_MIN_RST;
            r_cfg.bit_threshold <= BIT_THRESHOLD_RST;
            r_cfg.gap_max       <= GAP_MAX_RST;
        end else if (i_we) begin
            unique case (i_idx)
                CFG_LEADER_MIN:    r_cfg.leader_min    <= i_wdata;
                CFG_BIT_THRESHOLD: r_cfg.bit_threshold <= i_wdata;
                CFG_GAP_MAX:       r_cfg.gap_max       <= i_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: design/ird_frame.sv
// Frame state machine: leader check, bit shifting, frame completion and abort
`include "ir_pulse_distance_frame_decoder_defines.svh"

module ird_frame
    import ird_pkg::*;
#(
    parameter int unsigned FRAME_BITS = FRAME_BITS_D
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [BYTE_W-1:0] i_interval,
    input  t_cfg              i_cfg,
    output t_result           o_res
);

    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(FRAME_BITS);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_ARMED = 2'd1,
        PH_RECV  = 2'd2
    } t_phase;

    t_phase                              r_phase, n_phase;
    logic [CNT_W-1:0]                    r_bits, n_bits;
    logic [FRAME_BYTES-1:0][BYTE_W-1:0]  r_bytes, n_bytes;
    logic [FRAME_BYTES-1:0][BYTE_W-1:0]  w_upd;
    logic [1:0]                          w_k;
    logic [CNT_W-1:0]                    w_cnt_inc;
    t_result                             w_res;

    assign w_k       = r_bits[4:3];
    assign w_cnt_inc = r_bits + CNT_W'(1);

    always_comb begin
        n_phase      = r_phase;
        n_bits       = r_bits;
        n_bytes      = r_bytes;
        w_upd        = r_bytes;
        w_upd[w_k]   = {1'b0, r_bytes[w_k][BYTE_W-1:1]};
        w_res.valid  = 1'b0;
        w_res.status = ST_OK;
        w_res.bytes  = w_upd;
        unique case (r_phase)
            PH_ARMED: begin
                if (i_interval < i_cfg.leader_min) begin
                    n_phase = PH_IDLE;
                end else begin
                    n_phase = PH_RECV;
                    n_bits  = '0;
                end
            end
            PH_RECV: begin
                if (i_interval > i_cfg.gap_max) begin
                    w_res.valid  = 1'b1;
                    w_res.status = ST_ABORT;
                    n_phase      = PH_IDLE;
                    n_bits       = '0;
                    n_bytes      = '0;
                end else begin
                    w_upd[w_k][BYTE_W-1] = i_interval > i_cfg.bit_threshold;
                    w_res.bytes          = w_upd;
                    n_bytes              = w_upd;
                    n_bits               = w_cnt_inc;
                    if (w_cnt_inc >= LAST_CNT) begin
                        w_res.valid  = 1'b1;
                        w_res.status = (w_upd[2] == ~w_upd[3]) ? ST_OK : ST_CHECK_FAIL;
                        n_phase      = PH_IDLE;
                        n_bits       = '0;
                    end
                end
            end
            default: n_phase = PH_ARMED;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_bits  <= '0;
            r_bytes <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_bits  <= n_bits;
            r_bytes <= n_bytes;
        end
    end

    assign o_res = w_res;

    `IRD_ASSERT(a_abort_clears,
        i_fire && o_res.valid && o_res.status == ST_ABORT |=>
            r_phase == PH_IDLE && r_bits == '0 && r_bytes == '0,
        "abort did not clear the frame state")
    `IRD_ASSERT(a_done_idle,
        i_fire && o_res.valid |=> r_phase == PH_IDLE && r_bits == '0,
        "result not followed by idle")
    `IRD_ASSERT(a_result_in_recv,
        o_res.valid |-> r_phase == PH_RECV,
        "result outside data reception")
    `IRD_ASSERT_ALWAYS(a_count_bound,
        r_phase == PH_RECV |-> r_bits < LAST_CNT,
        "bit count ran past the frame length")

endmodule

// File: design/ir_pulse_distance_frame_decoder.sv
// Top level of the IR pulse distance frame decoder
//
// channel  dir  handshake               payload (low bit up)
// s        in   i_s_tvalid/o_s_tready   tdata: interval_units[7:0]
// m        out  o_m_tvalid/i_m_tready   tdata: status, address_byte, address_inverse,
//                                              command_byte, command_inverse, pad
// cfg      in   i_cfg_we                i_cfg_idx, i_cfg_wdata
//
// One edge per cycle while no held result stalls the input; a frame result is taken
// from the edge that ends it through input register, frame state logic, result register.
// Reset is synchronous, active low; it restores register defaults and idles the frame.
// A held result stalls the input register only when the next edge also yields a result.
module ir_pulse_distance_frame_decoder
    import ird_pkg::*;
#(
    parameter int unsigned FRAME_BITS = FRAME_BITS_D
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // interval_units[7:0]
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,   // status, addr, addr_inv, cmd, cmd_inv, 0
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [BYTE_W-1:0]      i_cfg_wdata
);

    localparam int unsigned PAD_W = OUT_TDATA_W - STATUS_W - FRAME_BYTES * BYTE_W;

    t_cfg                        w_cfg;
    t_result                     w_res;
    logic                        r_in_valid;
    logic [BYTE_W-1:0]           r_in_data;
    logic                        r_out_valid;
    logic [OUT_TDATA_W-1:0]      r_out_data;
    logic                        w_advance;

    ird_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_wdata (i_cfg_wdata),
        .o_cfg   (w_cfg)
    );

    ird_frame #(
        .FRAME_BITS (FRAME_BITS)
    ) u_frame (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (w_advance),
        .i_interval (r_in_data),
        .i_cfg      (w_cfg),
        .o_res      (w_res)
    );

    assign w_advance  = r_in_valid && (!w_res.valid || !r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (w_advance && w_res.valid) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_data <= i_s_tdata[BYTE_W-1:0];
        end
        if (w_advance && w_res.valid) begin
            r_out_data <= {PAD_W'(0), w_res.bytes, w_res.status};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule
